[hw/rtl/cqig_pkg.sv]
// Package for the cuboid quad index generator.
// Holds widths, register indexes, side codes and the structs shared between the modules.
// No dependencies.
package cqig_pkg;

  localparam int MAX_POINTS_PER_AXIS = 256;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = $clog2(MAX_POINTS_PER_AXIS);
  localparam int IDX_W     = 19;
  localparam int SIDE_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_FRONT  = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_BACK   = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd4;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd5;

  typedef struct packed {
    logic [CFG_W-1:0] x;
    logic [CFG_W-1:0] y;
    logic [CFG_W-1:0] z;
    logic [IDX_W-1:0] xy;
    logic [IDX_W-1:0] ring;
  } cfg_t;

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic [CNT_W-1:0]  col;
    logic [IDX_W-1:0]  xc;
    logic [IDX_W-1:0]  base1;
    logic [IDX_W-1:0]  base2;
    logic [IDX_W-1:0]  qn;
    logic              last;
    logic              row_first;
    logic              row_last;
    logic              col_first;
    logic              col_last;
  } work_t;

endpackage

[hw/rtl/cqig_if.sv]
// Handshake interfaces for the request and quad channels.
// Depends on cqig_pkg for the payload widths.
interface cqig_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface cqig_quad_if import cqig_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  corner_a;
  logic [IDX_W-1:0]  corner_b;
  logic [IDX_W-1:0]  corner_c;
  logic [IDX_W-1:0]  corner_d;
  logic [IDX_W-1:0]  quad_number;
  logic [SIDE_W-1:0] side;
  logic              final_quad;
  modport source (output valid, output corner_a, output corner_b, output corner_c,
                  output corner_d, output quad_number, output side, output final_quad,
                  input ready);
  modport sink (input valid, input corner_a, input corner_b, input corner_c,
                input corner_d, input quad_number, input side, input final_quad,
                output ready);
endinterface

[hw/rtl/cuboid_quad_index_generator_top.sv]
// Cuboid quad index generator, top level: grid registers, face sequencer, corner stage.
// Pipeline: sequencer work register, then corner output register. One quad per cycle
// with no output stall, set by the sequencer's single add per counter and row base.
// Reset: grids are 2 x 2 x 2 and the sequence is finished, so requests give no quad until
// a restart request. A grid write also ends the sequence.
// Depends on cqig_pkg, cqig_if, cqig_cfg, cqig_seq and cqig_corner.
module cuboid_quad_index_generator_top import cqig_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  cqig_req_if.sink             req,
  cqig_quad_if.source          quad
);

  cfg_t  cfg;
  logic  clear;
  logic  work_valid;
  logic  work_ready;
  work_t work;

  cqig_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .clear     (clear)
  );

  cqig_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clear      (clear),
    .req        (req),
    .work_valid (work_valid),
    .work       (work),
    .work_ready (work_ready)
  );

  cqig_corner u_corner (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .work_valid (work_valid),
    .work       (work),
    .work_ready (work_ready),
    .quad       (quad)
  );

endmodule

[hw/rtl/cqig_cfg.sv]
// Grid size registers with clamping and the derived layer sizes.
// Depends on cqig_pkg.
module cqig_cfg import cqig_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg,
  output logic                 clear
);

  logic [CFG_W-1:0] wv;
  logic [CFG_W-1:0] x_next;
  logic [CFG_W-1:0] y_next;
  logic [CFG_W-1:0] z_next;

  always_comb begin
    if (cfg_wdata < CFG_W'(2)) begin
      wv = CFG_W'(2);
    end else if (int'(cfg_wdata) > MAX_POINTS_PER_AXIS) begin
      wv = CFG_W'(MAX_POINTS_PER_AXIS);
    end else begin
      wv = cfg_wdata;
    end
    x_next = cfg.x;
    y_next = cfg.y;
    z_next = cfg.z;
    clear  = 1'b0;
    if (cfg_wen) begin
      case (cfg_index)
        REG_GRID_X: begin
          x_next = wv;
          clear  = 1'b1;
        end
        REG_GRID_Y: begin
          y_next = wv;
          clear  = 1'b1;
        end
        REG_GRID_Z: begin
          z_next = wv;
          clear  = 1'b1;
        end
        default: clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x    <= CFG_W'(2);
      cfg.y    <= CFG_W'(2);
      cfg.z    <= CFG_W'(2);
      cfg.xy   <= IDX_W'(4);
      cfg.ring <= IDX_W'(4);
    end else if (clear) begin
      cfg.x    <= x_next;
      cfg.y    <= y_next;
      cfg.z    <= z_next;
      cfg.xy   <= IDX_W'(x_next) * IDX_W'(y_next);
      cfg.ring <= (IDX_W'(x_next) << 1) + (IDX_W'(y_next) << 1) - IDX_W'(4);
    end
  end

endmodule

[hw/rtl/cqig_seq.sv]
// Face sequencer: side, row and column counters and the running row bases. Depends on cqig_pkg
// and the request interface; feeds one quad per cycle to the corner stage unless stalled.
module cqig_seq import cqig_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       clear,
  cqig_req_if.sink   req,
  output logic       work_valid,
  output work_t      work,
  input  logic       work_ready
);

  logic [SIDE_W-1:0] side, side_next, c_side;
  logic [CNT_W-1:0]  row, row_next, c_row;
  logic [CNT_W-1:0]  col, col_next, c_col;
  logic [IDX_W-1:0]  xc, xc_next, c_xc;
  logic [IDX_W-1:0]  base1, base1_next, c_b1;
  logic [IDX_W-1:0]  base2, base2_next, c_b2;
  logic [IDX_W-1:0]  qn, c_qn;
  logic              finished;
  logic              emit, accept, advance;
  logic [CFG_W-1:0]  ex, ey, ez, cols, rows;
  logic              col_end, row_end, last_quad;
  logic [IDX_W-1:0]  x_ext, ex_ext;
  work_t             cur;

  assign advance   = !work_valid || work_ready;
  assign req.ready = advance;
  assign accept    = req.valid && advance;

  always_comb begin
    emit   = req.restart || !finished;
    c_side = req.restart ? SIDE_BOTTOM : side;
    c_row  = req.restart ? '0 : row;
    c_col  = req.restart ? '0 : col;
    c_xc   = req.restart ? '0 : xc;
    c_b1   = req.restart ? '0 : base1;
    c_b2   = req.restart ? IDX_W'(cfg.x) : base2;
    c_qn   = req.restart ? '0 : qn;
    ex     = cfg.x - CFG_W'(1);
    ey     = cfg.y - CFG_W'(1);
    ez     = cfg.z - CFG_W'(1);
    x_ext  = IDX_W'(cfg.x);
    ex_ext = IDX_W'(ex);
    cols   = (c_side == SIDE_LEFT || c_side == SIDE_RIGHT) ? ey : ex;
    rows   = (c_side == SIDE_BOTTOM || c_side == SIDE_TOP) ? ey : ez;
    col_end   = (CFG_W'(c_col) + CFG_W'(1)) == cols;
    row_end   = (CFG_W'(c_row) + CFG_W'(1)) == rows;
    last_quad = (c_side == SIDE_RIGHT) && row_end && col_end;

    cur.side      = c_side;
    cur.col       = c_col;
    cur.xc        = c_xc;
    cur.base1     = c_b1;
    cur.base2     = c_b2;
    cur.qn        = c_qn;
    cur.last      = last_quad;
    cur.row_first = c_row == '0;
    cur.row_last  = (CFG_W'(c_row) + CFG_W'(1)) == ez;
    cur.col_first = c_col == '0;
    cur.col_last  = (CFG_W'(c_col) + CFG_W'(1)) == ey;

    side_next  = c_side;
    row_next   = c_row;
    col_next   = c_col;
    xc_next    = c_xc;
    base1_next = c_b1;
    base2_next = c_b2;
    if (!last_quad) begin
      if (!col_end) begin
        col_next = c_col + CNT_W'(1);
        xc_next  = c_xc + x_ext;
      end else begin
        col_next = '0;
        xc_next  = '0;
        if (!row_end) begin
          row_next = c_row + CNT_W'(1);
          case (c_side)
            SIDE_BOTTOM, SIDE_TOP: begin
              base1_next = c_b1 + x_ext;
              base2_next = c_b2 + x_ext;
            end
            SIDE_FRONT, SIDE_LEFT, SIDE_RIGHT: begin
              base1_next = c_b2;
              base2_next = c_b2 + cfg.ring;
            end
            SIDE_BACK: base1_next = c_b1 + cfg.ring;
            default: base1_next = c_b1;
          endcase
        end else begin
          row_next  = '0;
          side_next = c_side + SIDE_W'(1);
          case (c_side)
            SIDE_BOTTOM, SIDE_BACK: begin
              base1_next = '0;
              base2_next = cfg.xy;
            end
            SIDE_FRONT: begin
              base1_next = c_b2;
              base2_next = c_b2 + x_ext;
            end
            SIDE_TOP: base1_next = cfg.xy - x_ext;
            SIDE_LEFT: begin
              base1_next = ex_ext;
              base2_next = ex_ext + cfg.xy;
            end
            default: base1_next = c_b1;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished   <= 1'b1;
      work_valid <= 1'b0;
    end else begin
      if (advance) begin
        work_valid <= accept && emit;
      end
      if (accept && emit) begin
        finished <= last_quad;
      end
      if (clear) begin
        finished <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      work  <= cur;
      side  <= side_next;
      row   <= row_next;
      col   <= col_next;
      xc    <= xc_next;
      base1 <= base1_next;
      base2 <= base2_next;
      qn    <= c_qn + IDX_W'(1);
    end
  end

endmodule

[hw/rtl/cqig_corner.sv]
// Corner stage: turns a sequencer transaction into four vertex indices.
// Depends on cqig_pkg and the quad interface; holds the output register.
module cqig_corner import cqig_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        work_valid,
  input  work_t       work,
  output logic        work_ready,
  cqig_quad_if.source quad
);

  logic [IDX_W-1:0] c_ext, two_c, x_ext, xm2, hi;
  logic [IDX_W-1:0] va, vb, vc, vd;
  logic             full1, full2;

  assign work_ready = !quad.valid || quad.ready;

  always_comb begin
    c_ext = IDX_W'(work.col);
    two_c = c_ext << 1;
    x_ext = IDX_W'(cfg.x);
    xm2   = x_ext - IDX_W'(2);
    hi    = work.row_last ? work.base1 + cfg.xy : work.base1 + cfg.ring;
    full1 = 1'b0;
    full2 = 1'b0;
    case (work.side)
      SIDE_BOTTOM: begin
        va = work.base1 + c_ext;
        vb = work.base2 + c_ext;
        vc = vb + IDX_W'(1);
        vd = va + IDX_W'(1);
      end
      SIDE_FRONT, SIDE_TOP: begin
        va = work.base1 + c_ext;
        vb = va + IDX_W'(1);
        vd = work.base2 + c_ext;
        vc = vd + IDX_W'(1);
      end
      SIDE_BACK: begin
        va = work.base1 + c_ext;
        vd = va + IDX_W'(1);
        vb = hi + c_ext;
        vc = vb + IDX_W'(1);
      end
      SIDE_LEFT: begin
        full1 = work.row_first || work.col_first;
        full2 = work.col_first || work.row_last;
        va = work.base1 + (full1 ? work.xc : two_c + xm2);
        vd = va + (full1 ? x_ext : IDX_W'(2));
        vb = work.base2 + (full2 ? work.xc : two_c + xm2);
        vc = vb + (full2 ? x_ext : IDX_W'(2));
      end
      SIDE_RIGHT: begin
        full1 = work.row_first || work.col_last;
        full2 = work.row_last || work.col_last;
        va = work.base1 + (work.row_first ? work.xc : two_c);
        vb = va + (full1 ? x_ext : IDX_W'(2));
        vd = work.base2 + (work.row_last ? work.xc : two_c);
        vc = vd + (full2 ? x_ext : IDX_W'(2));
      end
      default: begin
        va = '0;
        vb = '0;
        vc = '0;
        vd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quad.valid <= 1'b0;
    end else if (work_ready) begin
      quad.valid <= work_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work_valid && work_ready) begin
      quad.corner_a    <= va;
      quad.corner_b    <= vb;
      quad.corner_c    <= vc;
      quad.corner_d    <= vd;
      quad.quad_number <= work.qn;
      quad.side        <= work.side;
      quad.final_quad  <= work.last;
    end
  end

endmodule

[tb/tb.sv]
// Testbench for cuboid_quad_index_generator_top: a built-in predictor of the face walk checks every
// quad transaction field by field, under random request gaps and result stalls.
// Depends on cqig_pkg, cqig_if and the RTL of the generator.
module tb;
  import cqig_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 2;
  localparam int RANDOM_QUADS = 900;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  corner_a;
    logic [IDX_W-1:0]  corner_b;
    logic [IDX_W-1:0]  corner_c;
    logic [IDX_W-1:0]  corner_d;
    logic [IDX_W-1:0]  quad_number;
    logic [SIDE_W-1:0] side;
    logic              final_quad;
  } quad_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  cqig_req_if  req_ch ();
  cqig_quad_if quad_ch ();

  cuboid_quad_index_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .quad      (quad_ch)
  );

  longint unsigned   grid_x, grid_y, grid_z;
  logic [SIDE_W-1:0] cur_side;
  longint unsigned   cur_row, cur_col;
  logic [IDX_W-1:0]  next_qn;
  bit                seq_done;

  quad_t       quads_due[$];
  int unsigned quads_predicted;
  int unsigned errors;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[cuboid_quad_index_generator_top] ERROR");
    $finish;
  end

  function automatic longint unsigned clamp_grid(input logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_POINTS_PER_AXIS) return MAX_POINTS_PER_AXIS;
    return v;
  endfunction

  function automatic void clear_walk();
    cur_side = SIDE_BOTTOM;
    cur_row  = 0;
    cur_col  = 0;
    next_qn  = '0;
  endfunction

  function automatic longint unsigned layer_base(input longint unsigned z);
    longint unsigned ring;
    ring = 2 * grid_x + 2 * grid_y - 4;
    if (z == 0) return 0;
    return grid_x * grid_y + (z - 1) * ring;
  endfunction

  function automatic bit compute_quad(input logic rs, output quad_t q);
    longint unsigned x, y, ex, ey, ez, ring, r, c, b1, b2;
    longint unsigned v1, v2, v3, v4, qa, qb, qc, qd, ncols, nrows;
    bit is_last;
    x = grid_x;
    y = grid_y;
    ex = x - 1;
    ey = y - 1;
    ez = grid_z - 1;
    ring = 2 * x + 2 * y - 4;
    q = '0;
    if (rs) begin
      clear_walk();
      seq_done = 1'b0;
    end
    if (seq_done) return 1'b0;
    r = cur_row;
    c = cur_col;
    case (cur_side)
      SIDE_BOTTOM, SIDE_BACK: begin
        if (cur_side == SIDE_BOTTOM) begin
          b1 = r * x;
          b2 = b1 + x;
        end else begin
          b1 = x * ey + r * ring;
          b2 = x * ey + (r + 1) * ring;
          if (r == ez - 1) b2 += (x - 2) * (y - 2);
        end
        qa = b1 + c;
        qb = b2 + c;
        qc = qb + 1;
        qd = qa + 1;
      end
      SIDE_FRONT, SIDE_TOP: begin
        if (cur_side == SIDE_FRONT) begin
          b1 = layer_base(r);
          b2 = layer_base(r + 1);
        end else begin
          b1 = layer_base(ez) + r * x;
          b2 = b1 + x;
        end
        qa = b1 + c;
        qb = qa + 1;
        qd = b2 + c;
        qc = qd + 1;
      end
      SIDE_LEFT: begin
        b1 = layer_base(r);
        b2 = layer_base(r + 1);
        if (r == 0 || c == 0) begin
          v1 = b1 + x * c;
          v4 = v1 + x;
        end else begin
          v1 = b1 + 2 * c + x - 2;
          v4 = v1 + 2;
        end
        if (c == 0 || r == ez - 1) begin
          v2 = b2 + x * c;
          v3 = v2 + x;
        end else begin
          v2 = b2 + 2 * c + x - 2;
          v3 = v2 + 2;
        end
        qa = v1;
        qb = v2;
        qc = v3;
        qd = v4;
      end
      default: begin
        b1 = ex + layer_base(r);
        b2 = ex + layer_base(r + 1);
        if (r == 0) begin
          v1 = b1 + x * c;
          v4 = v1 + x;
        end else begin
          v1 = b1 + 2 * c;
          v4 = v1 + 2;
        end
        if (r == ez - 1) begin
          v2 = b2 + x * c;
          v3 = v2 + x;
        end else begin
          v2 = b2 + 2 * c;
          v3 = v2 + 2;
        end
        if (c == ey - 1) begin
          v3 = v2 + x;
          v4 = v1 + x;
        end
        qa = v1;
        qb = v4;
        qc = v3;
        qd = v2;
      end
    endcase
    is_last = (cur_side == SIDE_RIGHT) && (r == ez - 1) && (c == ey - 1);
    q.corner_a    = qa[IDX_W-1:0];
    q.corner_b    = qb[IDX_W-1:0];
    q.corner_c    = qc[IDX_W-1:0];
    q.corner_d    = qd[IDX_W-1:0];
    q.quad_number = next_qn;
    q.side        = cur_side;
    q.final_quad  = is_last;
    next_qn = next_qn + 1'b1;
    if (is_last) begin
      seq_done = 1'b1;
    end else begin
      ncols = (cur_side == SIDE_LEFT || cur_side == SIDE_RIGHT) ? ey : ex;
      nrows = (cur_side == SIDE_BOTTOM || cur_side == SIDE_TOP) ? ey : ez;
      cur_col++;
      if (cur_col >= ncols) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= nrows) begin
          cur_row = 0;
          cur_side = cur_side + 1'b1;
        end
      end
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    quad_t want;
    quad_t fresh;
    if (rst) begin
      grid_x = 2;
      grid_y = 2;
      grid_z = 2;
      clear_walk();
      seq_done = 1'b1;
    end else begin
      if (quad_ch.valid && quad_ch.ready) begin
        if (quads_due.size() == 0) begin
          $error("quad transaction with no request waiting: quad_number %0d",
                 quad_ch.quad_number);
          errors++;
        end else begin
          want = quads_due.pop_front();
          check_field("corner_a", want.corner_a, quad_ch.corner_a);
          check_field("corner_b", want.corner_b, quad_ch.corner_b);
          check_field("corner_c", want.corner_c, quad_ch.corner_c);
          check_field("corner_d", want.corner_d, quad_ch.corner_d);
          check_field("quad_number", want.quad_number, quad_ch.quad_number);
          check_field("side", want.side, quad_ch.side);
          check_field("final_quad", want.final_quad, quad_ch.final_quad);
        end
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_GRID_X: grid_x = clamp_grid(cfg_wdata);
          REG_GRID_Y: grid_y = clamp_grid(cfg_wdata);
          REG_GRID_Z: grid_z = clamp_grid(cfg_wdata);
          default: ;
        endcase
        if (cfg_index != REG_NONE) begin
          clear_walk();
          seq_done = 1'b1;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        if (compute_quad(req_ch.restart, fresh)) begin
          quads_due.push_back(fresh);
          quads_predicted++;
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin : quad_ready_driver
    int unsigned n;
    quad_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n != 0) begin
        quad_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      quad_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic send_request(input logic rs);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.restart <= rs;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (quads_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  task automatic write_grid(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_wen   <= 1'b1;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_idle_after_reset();
    send_request(1'b0);
    send_request(1'b0);
    drain();
  endtask

  task automatic test_min_cuboid();
    send_request(1'b1);
    repeat (5) send_request(1'b0);
    send_request(1'b0);
    send_request(1'b0);
    drain();
  endtask

  task automatic test_restart_mid_sequence();
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain();
  endtask

  task automatic test_grid_clamp();
    write_grid(REG_GRID_X, 9'd0);
    write_grid(REG_GRID_Y, 9'd1);
    write_grid(REG_GRID_Z, 9'h1FF);
    write_grid(REG_NONE, 9'h1FF);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    drain();
    write_grid(REG_GRID_X, 9'd257);
    write_grid(REG_GRID_Y, 9'd256);
    send_request(1'b1);
    send_request(1'b0);
    drain();
  endtask

  task automatic test_write_ends_sequence();
    write_grid(REG_GRID_X, 9'd3);
    write_grid(REG_GRID_Y, 9'd2);
    write_grid(REG_GRID_Z, 9'd2);
    send_request(1'b1);
    send_request(1'b0);
    drain();
    write_grid(REG_GRID_Y, 9'd3);
    send_request(1'b0);
    send_request(1'b1);
    drain();
  endtask

  function automatic logic [CFG_W-1:0] pick_extreme_grid();
    int unsigned k;
    k = $urandom_range(0, 7);
    case (k)
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd2;
      3: return 9'd255;
      4: return 9'd256;
      5: return 9'd257;
      6: return 9'h1FF;
      default: return CFG_W'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_small_grid();
    if ($urandom_range(0, 9) == 0) return CFG_W'($urandom_range(2, 12));
    return CFG_W'($urandom_range(2, 5));
  endfunction

  task automatic test_random_cuboids();
    bit big;
    int unsigned cap, n;
    int restart_at;
    while (quads_predicted < RANDOM_QUADS) begin
      quiet = ($urandom_range(0, 4) == 0);
      big = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 6) != 0)
        write_grid(REG_GRID_X, big ? pick_extreme_grid() : pick_small_grid());
      if ($urandom_range(0, 6) != 0)
        write_grid(REG_GRID_Y, big ? pick_extreme_grid() : pick_small_grid());
      if ($urandom_range(0, 6) != 0)
        write_grid(REG_GRID_Z, big ? pick_extreme_grid() : pick_small_grid());
      if ($urandom_range(0, 5) == 0)
        write_grid(REG_NONE, CFG_W'($urandom_range(0, 511)));
      cap = (grid_x > 12 || grid_y > 12 || grid_z > 12) ? 40 : 5000;
      restart_at = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 30)) : -1;
      repeat ($urandom_range(0, 2)) send_request(1'b0);
      send_request(1'b1);
      n = 0;
      while (!seq_done && n < cap) begin
        send_request(n == restart_at);
        n++;
      end
      repeat ($urandom_range(0, 2)) send_request(1'b0);
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    cfg_wen        = 1'b0;
    cfg_index      = REG_GRID_X;
    cfg_wdata      = '0;
    req_ch.valid   = 1'b0;
    req_ch.restart = 1'b0;
    quads_predicted = 0;
    errors         = 0;
    quiet          = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_idle_after_reset();
    test_min_cuboid();
    test_restart_mid_sequence();
    test_grid_clamp();
    test_write_ends_sequence();
    quads_predicted = 0;
    test_random_cuboids();
    drain();
    if (errors == 0 && quads_due.size() == 0) begin
      $display("[cuboid_quad_index_generator_top] OK");
    end else begin
      $display("[cuboid_quad_index_generator_top] ERROR");
    end
    $finish;
  end

endmodule

[cuboid_quad_index_generator_top.f]
hw/rtl/cqig_pkg.sv
hw/rtl/cqig_if.sv
hw/rtl/cqig_cfg.sv
hw/rtl/cqig_seq.sv
hw/rtl/cqig_corner.sv
hw/rtl/cuboid_quad_index_generator_top.sv
tb/tb.sv
